// ----- rtl/sem_pkg.sv -----
// Shared types and constants of the Sobel RGB edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
   localparam int SEM_MAX_WIDTH  = 1024;
   localparam int SEM_MAX_HEIGHT = 4096;

   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;
   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

   // Register select is address bit 2.
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam int PIX_W = 24;

   // One channel's 3x3 neighborhood, [column][row].
   typedef logic [2:0][2:0][7:0] pix_win_type;

   // Start pulse and border masks handed to each lane.
   typedef struct packed {
      logic       start;
      logic [2:0] colv;
      logic [2:0] rowv;
   } lane_ctl_type;
endpackage
`default_nettype wire

// ----- rtl/sem_line_store.sv -----
// Two row memories holding the previous two rows of the frame.
`timescale 1ns / 1ps
`default_nettype none
module sem_line_store
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = SEM_MAX_WIDTH,
   localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic              wr_pix_en,
   input  wire logic [PIX_W-1:0]  pix,
   input  wire logic              shift_en,
   output logic      [PIX_W-1:0]  older_rd,
   output logic      [PIX_W-1:0]  newer_rd
);
   logic [PIX_W-1:0] older_mem [MAX_WIDTH];
   logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
   logic [ADDR_W-1:0] addr_ff;
   logic [PIX_W-1:0] older_rd_ff;
   logic [PIX_W-1:0] newer_rd_ff;

   // Newer row: read old value and write the new pixel at the same address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         newer_rd_ff <= newer_mem[addr];
         addr_ff     <= addr;
      end
      if (wr_pix_en) begin
         newer_mem[addr] <= pix;
      end
   end

   // Older row: the displaced newer pixel moves down in the next cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         older_rd_ff <= older_mem[addr];
      end
      if (shift_en) begin
         older_mem[addr_ff] <= newer_rd_ff;
      end
   end

   assign older_rd = older_rd_ff;
   assign newer_rd = newer_rd_ff;
endmodule
`default_nettype wire

// ----- rtl/sem_lane.sv -----
// One color lane: Sobel gradients, sum of squares and bit-serial rounded root.
`timescale 1ns / 1ps
`default_nettype none
module sem_lane
   import sem_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_ctl_type ctl,
   input  wire pix_win_type  win,
   output logic              done,
   output logic [7:0]        mag
);
   localparam logic [3:0] PH_SUM   = 4'd0;
   localparam logic [3:0] PH_ROUND = 4'd9;
   localparam logic [20:0] SAT_LIMIT = 21'd65280;

   logic signed [10:0] v [3][3];
   logic signed [10:0] gx_in, gy_in, dx1, dy1;
   logic signed [10:0] gx_ff, gy_ff;
   logic [20:0] sum_ff;
   logic [7:0]  root_ff, mag_ff;
   logic [3:0]  phase_ff;
   logic        busy_ff, done_ff;
   logic [2:0]  bit_idx;
   logic [7:0]  trial, mul_op;
   logic [15:0] prod, rem;
   logic signed [21:0] sqx, sqy;

   // Mask positions outside the frame and form the gradients.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            v[c][r] = (ctl.colv[c] && ctl.rowv[r]) ? $signed({3'b000, win[c][r]}) : 11'sd0;
         end
      end
      dx1   = v[2][1] - v[0][1];
      dy1   = v[1][2] - v[1][0];
      gx_in = (v[2][0] - v[0][0]) + dx1 + dx1 + (v[2][2] - v[0][2]);
      gy_in = (v[0][2] - v[0][0]) + dy1 + dy1 + (v[2][2] - v[2][0]);
   end

   // Shared multiplier: trial squares during the root, then the final square.
   always_comb begin
      bit_idx = 3'(4'd8 - phase_ff);
      trial   = root_ff | (8'd1 << bit_idx);
      mul_op  = (phase_ff == PH_ROUND) ? root_ff : trial;
      prod    = mul_op * mul_op;
      rem     = sum_ff[15:0] - prod;
      sqx     = gx_ff * gx_ff;
      sqy     = gy_ff * gy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_SUM;
      end else if (ctl.start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         phase_ff <= PH_SUM;
      end else if (busy_ff) begin
         phase_ff <= phase_ff + 4'd1;
         if (phase_ff == PH_ROUND) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         root_ff <= 8'd0;
      end else if (busy_ff) begin
         if (phase_ff == PH_SUM) begin
            sum_ff <= 21'(sqx) + 21'(sqy);
         end else if (phase_ff == PH_ROUND) begin
            if (sum_ff > SAT_LIMIT) begin
               mag_ff <= 8'd255;
            end else if (rem > {8'd0, root_ff}) begin
               mag_ff <= root_ff + 8'd1;
            end else begin
               mag_ff <= root_ff;
            end
         end else if ({5'd0, prod} <= sum_ff) begin
            root_ff <= trial;
         end
      end
   end

   assign done = done_ff;
   assign mag  = mag_ff;
endmodule
`default_nettype wire

// ----- rtl/sobel_edge_magnitude_rgb_unit.sv -----
// Top level of the 3x3 Sobel edge magnitude block for RGB pixel streams.
//
// Pixels enter on the req_ stream in raster order, one per request; req_tuser
// high marks a drain request. Results leave on the rsp_ stream, lagging the
// input by one row plus one pixel; after the frame's last pixel, width+1
// drain requests flush the rest, and rsp_tlast flags the frame's last result.
// Frame width and height are set through the csr_ port (byte addresses 0 and
// 4); a write restarts the frame.
// A request that yields a result runs through these steps from acceptance:
// a gradient step on the row data read at acceptance, a sum of squares step,
// a root step per magnitude bit in the bit-serial roots of the three color
// lanes, a rounding step and the load into the output register. The next
// request is taken only after that load, so such requests do not overlap.
// A request without a result still waits out its memory read; a drain
// request during the pixel phase is absorbed without leaving the idle state.
// The output register lets the next request enter while a result waits;
// a stalled receiver holds the result and stops the lanes from unloading.
// Reset clears positions, window and control; row memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb_unit
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH  = SEM_MAX_WIDTH,
   parameter int MAX_HEIGHT = SEM_MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red, green, blue
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // edge_red, edge_green, edge_blue
   output logic             rsp_tlast,   // frame_end
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   localparam int COL_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_W = $clog2(MAX_WIDTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LANE = 2'd2;

   typedef logic [2:0][2:0][PIX_W-1:0] win24_type;

   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0] w_eff, in_col_ff, out_col_ff;
   logic [ROW_W-1:0] h_eff, in_row_ff, out_row_ff;
   logic [1:0] state_ff;
   logic cfg_wr, restart, accept, draining, active, in_range, emit, last;
   logic emit_ff, last_ff, range_ff, avail_ff;
   logic [2:0] colv, rowv, colv_ff, rowv_ff;
   logic [PIX_W-1:0] pix_in, pix_ff, older_rd, newer_rd;
   win24_type window_ff, win_next;
   lane_ctl_type lane_ctl;
   pix_win_type lane_win [3];
   logic [2:0] lane_done;
   logic [7:0] lane_mag [3];
   logic rsp_valid_ff, rsp_last_ff, load_out;
   logic [23:0] rsp_data_ff;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign restart    = cfg_wr;
   assign csr_prdata = (csr_paddr[2] == REG_FRAME_HEIGHT) ? 32'(height_ff) : 32'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (cfg_wr) begin
         if (csr_paddr[2] == REG_FRAME_WIDTH) begin
            width_ff <= csr_pwdata[CFG_WIDTH_W-1:0];
         end else begin
            height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
         end
      end
   end

   // Clamp the frame size to 1..maximum.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = COL_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = COL_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(height_ff);
      end
   end

   // Request decode against the current stream position.
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      draining   = (in_row_ff >= h_eff);
      active     = !(!draining && req_tuser);
      in_range   = (in_col_ff < w_eff);
      emit       = (in_row_ff >= ROW_W'(2)) || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      last       = draining && (in_col_ff >= w_eff);
      colv = {({1'b0, out_col_ff} + 1'b1) < {1'b0, w_eff}, 1'b1, out_col_ff != '0};
      rowv = {({1'b0, out_row_ff} + 1'b1) < {1'b0, h_eff}, 1'b1, out_row_ff != '0};
      pix_in = (in_range && !draining) ? req_tdata : '0;
   end

   // Stream positions and control state.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff   <= ST_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && active) begin
                  state_ff <= ST_READ;
                  if (emit) begin
                     if (({1'b0, out_col_ff} + 1'b1) >= {1'b0, w_eff}) begin
                        out_col_ff <= '0;
                        out_row_ff <= out_row_ff + 1'b1;
                     end else begin
                        out_col_ff <= out_col_ff + 1'b1;
                     end
                  end
                  if (last) begin
                     in_col_ff  <= '0;
                     in_row_ff  <= '0;
                     out_col_ff <= '0;
                     out_row_ff <= '0;
                  end else if (!draining &&
                               (({1'b0, in_col_ff} + 1'b1) >= {1'b0, w_eff})) begin
                     in_col_ff <= '0;
                     in_row_ff <= in_row_ff + 1'b1;
                  end else begin
                     in_col_ff <= in_col_ff + 1'b1;
                  end
               end
            end
            ST_READ: begin
               state_ff <= emit_ff ? ST_LANE : ST_IDLE;
            end
            ST_LANE: begin
               if (load_out) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Per-request payload held across the memory read.
   always_ff @(posedge clock) begin
      if (accept) begin
         emit_ff  <= emit;
         last_ff  <= last;
         range_ff <= in_range && !draining;
         avail_ff <= in_range;
         colv_ff  <= colv;
         rowv_ff  <= rowv;
         pix_ff   <= pix_in;
      end
   end

   sem_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept && active),
      .addr      (in_col_ff[ADDR_W-1:0]),
      .wr_pix_en (accept && active && in_range && !draining),
      .pix       (req_tdata),
      .shift_en  ((state_ff == ST_READ) && range_ff),
      .older_rd  (older_rd),
      .newer_rd  (newer_rd)
   );

   // Shift the window one column; the new column's top two come from memory.
   // Drain requests inside the row still read both stored rows.
   always_comb begin
      win_next[0] = window_ff[1];
      win_next[1] = window_ff[2];
      win_next[2][0] = avail_ff ? older_rd : '0;
      win_next[2][1] = avail_ff ? newer_rd : '0;
      win_next[2][2] = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         window_ff <= '0;
      end else if (state_ff == ST_READ) begin
         window_ff <= last_ff ? '0 : win_next;
      end
   end

   // Color lanes, started from the shifted window; lane 0 is red.
   assign lane_ctl.start = (state_ff == ST_READ) && emit_ff;
   assign lane_ctl.colv  = colv_ff;
   assign lane_ctl.rowv  = rowv_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
               lane_win[ch][c][r] = win_next[c][r][ch * 8 +: 8];
            end
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sem_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .win   (lane_win[g]),
         .done  (lane_done[g]),
         .mag   (lane_mag[g])
      );
   end

   // Merge the lane results into the output register.
   assign load_out = (state_ff == ST_LANE) && (&lane_done) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {lane_mag[2], lane_mag[1], lane_mag[0]};
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
endmodule
`default_nettype wire

// ----- rtl/sem_checker.sv -----
// Port-level checks on the Sobel edge block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_pready
);
   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No result right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A pixel request occupies the block for at least the memory read.
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !req_tready)
      else $error("request taken during memory read");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");
endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench for the Sobel RGB edge magnitude block.
`timescale 1ns / 1ps
module tb;
   import sem_pkg::*;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;
   localparam int   STALL_LIMIT = 2000;
   localparam int   SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } grad_result_type;

   typedef struct {
      logic            func;
      logic [7:0]      red;
      logic [7:0]      green;
      logic [7:0]      blue;
      bit              typed;
      bit              has_result;
      grad_result_type result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sobel_edge_magnitude_rgb_unit dut (.*);

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: row stores, window, stream positions and frame size.
   logic [23:0]     older_row [SEM_MAX_WIDTH];
   logic [23:0]     newer_row [SEM_MAX_WIDTH];
   logic [23:0]     window [3][3];
   int unsigned     in_col, in_row, out_col, out_row;
   int unsigned     frame_w, frame_h;
   grad_result_type pending_edges[$];
   int              failures = 0;
   int              received = 0;
   int              sent_small = 0;
   bit              quiet = 0;
   int              stall_cycles = 0;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void restart_frame();
      foreach (window[c, r]) window[c][r] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endfunction

   // Rounded square root of gx^2 + gy^2, saturated to 255.
   function automatic logic [7:0] magnitude(int gx, int gy);
      int unsigned s, q, b;
      s = gx * gx + gy * gy;
      q = 0;
      if (s > 65280) return 8'd255;
      for (b = 128; b != 0; b = b >> 1)
         if ((q + b) * (q + b) <= s) q += b;
      if (s - q * q > q) q++;
      return q[7:0];
   endfunction

   function automatic logic [7:0] channel_grad(int sh, bit colv[3], bit rowv[3]);
      int v[3][3];
      int gx, gy;
      foreach (v[c, r]) v[c][r] = (colv[c] && rowv[r]) ? int'((window[c][r] >> sh) & 24'hFF) : 0;
      gx = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
      gy = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
      return magnitude(gx, gy);
   endfunction

   // Advances the predictor by one request; returns 1 when it yields a result.
   function automatic bit sobel_step(logic func, logic [23:0] rgb, output grad_result_type res);
      int unsigned w, h;
      bit          draining, emit, last;
      logic [23:0] col[3];
      bit          colv[3], rowv[3];
      w = clamp_size(frame_w, SEM_MAX_WIDTH);
      h = clamp_size(frame_h, SEM_MAX_HEIGHT);
      draining = in_row >= h;
      res = '0;
      if (!draining && func == FUNC_DRAIN) return 0;
      col = '{24'd0, 24'd0, 24'd0};
      if (in_col < w) begin
         col[0] = older_row[in_col];
         col[1] = newer_row[in_col];
         if (!draining) begin
            col[2] = rgb;
            older_row[in_col] = col[1];
            newer_row[in_col] = col[2];
         end
      end
      for (int c = 0; c < 2; c++)
         for (int r = 0; r < 3; r++) window[c][r] = window[c + 1][r];
      for (int r = 0; r < 3; r++) window[2][r] = col[r];
      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      last = draining && in_col >= w;
      if (emit) begin
         colv = '{out_col >= 1, 1'b1, out_col + 1 < w};
         rowv = '{out_row >= 1, 1'b1, out_row + 1 < h};
         res.red = channel_grad(16, colv, rowv);
         res.green = channel_grad(8, colv, rowv);
         res.blue = channel_grad(0, colv, rowv);
         res.frame_end = last;
         if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
      end
      if (last) restart_frame();
      else if (!draining && in_col + 1 >= w) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
      return emit;
   endfunction

   // Offers one request, waits for acceptance, then records what it should yield.
   task automatic send_request(stim_row_type row);
      grad_result_type res;
      bit              got;
      req_tvalid <= 1'b1;
      req_tuser <= row.func;
      req_tdata <= {row.blue, row.green, row.red};
      do @(posedge clock); while (!req_tready);
      got = sobel_step(row.func, {row.red, row.green, row.blue}, res);
      if (row.typed) begin
         got = row.has_result;
         res = row.result;
      end
      if (got) pending_edges.push_back(res);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic send_random(logic func);
      stim_row_type row;
      row = '{func, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 0, 0, '0};
      send_request(row);
      sent_small++;
   endtask

   // Lets the block go idle: all results in, then time for result-less requests.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic reg_sel, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_sel == REG_FRAME_WIDTH) frame_w = value[CFG_WIDTH_W-1:0];
      else frame_h = value[CFG_HEIGHT_W-1:0];
      restart_frame();
   endtask

   // Writes both sizes; the upper data bits are random and must be ignored.
   task automatic set_frame(int unsigned w, int unsigned h);
      csr_write(REG_FRAME_WIDTH, {21'($urandom_range(0, 2 ** 21 - 1)), w[CFG_WIDTH_W-1:0]});
      csr_write(REG_FRAME_HEIGHT, {19'($urandom_range(0, 2 ** 19 - 1)), h[CFG_HEIGHT_W-1:0]});
   endtask

   // One frame with random content; may stop early to leave a broken frame.
   task automatic run_frame(int unsigned pixel_cap);
      int unsigned w, h, n;
      w = clamp_size(frame_w, SEM_MAX_WIDTH);
      h = clamp_size(frame_h, SEM_MAX_HEIGHT);
      n = (w * h < pixel_cap) ? w * h : pixel_cap;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) send_random(FUNC_DRAIN);
         send_random(FUNC_PIXEL);
      end
      if (n == w * h)
         for (int unsigned i = 0; i <= w; i++)
            send_random(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_DRAIN);
   endtask

   // Receiver: random stall bursts, plus long hold-offs at 80 received results.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (received == 80 && rsp_tready) begin
         stall_cycles <= 300;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_cycles <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker and watchdog.
   int idle_cycles = 0;
   always @(posedge clock) begin
      grad_result_type want;
      if (rsp_tvalid && rsp_tready) begin
         received <= received + 1;
         if (pending_edges.size() == 0) begin
            $error("result with none expected: data %h last %b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = pending_edges.pop_front();
            if (rsp_tdata[7:0] !== want.red) begin
               $error("edge_red expected %0d actual %0d", want.red, rsp_tdata[7:0]);
               failures++;
            end
            if (rsp_tdata[15:8] !== want.green) begin
               $error("edge_green expected %0d actual %0d", want.green, rsp_tdata[15:8]);
               failures++;
            end
            if (rsp_tdata[23:16] !== want.blue) begin
               $error("edge_blue expected %0d actual %0d", want.blue, rsp_tdata[23:16]);
               failures++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end expected %0d actual %0d", want.frame_end, rsp_tlast);
               failures++;
            end
         end
      end
      if (reset || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Directed rows: an all-zero 3x2 frame with its results typed in, then extremes.
   stim_row_type directed[$];
   function automatic void add_row(logic func, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   bit typed = 0, bit has_res = 0, bit fe = 0);
      directed.push_back('{func, r, g, b, typed, has_res, '{8'd0, 8'd0, 8'd0, fe}});
   endfunction

   initial begin
      foreach (older_row[i]) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      frame_w = WIDTH_RESET;
      frame_h = HEIGHT_RESET;
      restart_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_frame(3, 2);
      for (int i = 0; i < 3; i++) add_row(FUNC_PIXEL, 0, 0, 0, 1, 0);
      add_row(FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1, 0);
      add_row(FUNC_PIXEL, 0, 0, 0, 1, 0);
      add_row(FUNC_PIXEL, 0, 0, 0, 1, 1);
      add_row(FUNC_PIXEL, 0, 0, 0, 1, 1);
      for (int i = 0; i < 3; i++) add_row(FUNC_DRAIN, 0, 0, 0, 1, 1);
      add_row(FUNC_DRAIN, 0, 0, 0, 1, 1, 1);
      add_row(FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF);
      add_row(FUNC_PIXEL, 8'h00, 8'hFF, 8'h00);
      add_row(FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      add_row(FUNC_PIXEL, 8'h00, 8'h00, 8'h00);
      add_row(FUNC_PIXEL, 8'hFF, 8'h80, 8'h01);
      add_row(FUNC_PIXEL, 8'h7F, 8'hFE, 8'hFF);
      add_row(FUNC_PIXEL, 8'hAB, 8'hCD, 8'hEF);
      add_row(FUNC_DRAIN, 0, 0, 0);
      add_row(FUNC_PIXEL, 8'h55, 8'hAA, 8'h55);
      add_row(FUNC_DRAIN, 0, 0, 0);
      foreach (directed[i]) send_request(directed[i]);
      wait_idle();

      // Size extremes: zero sizes act as one; an oversize width wraps its rows at
      // the maximum, seen in the first pixels of the second row.
      set_frame(0, 0);
      run_frame(SEM_MAX_WIDTH * 4);
      wait_idle();
      set_frame(2047, 2);
      run_frame(SEM_MAX_WIDTH + 8);
      wait_idle();
      set_frame(1, 8191);
      run_frame(40);
      wait_idle();

      // Random small frames; some are cut short and restarted by the next write.
      sent_small = 0;
      while (sent_small < 200) begin
         quiet = sent_small > 150;
         if ($urandom_range(0, 9) == 0) set_frame($urandom_range(0, 40), $urandom_range(0, 8));
         else set_frame($urandom_range(1, 8), $urandom_range(1, 6));
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 7) == 0) run_frame($urandom_range(0, 30));
            else run_frame(SEM_MAX_WIDTH * SEM_MAX_HEIGHT);
         end
         wait_idle();
      end

      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
